/* rtl/sbsa_pkg.sv */
`default_nettype none

package sbsa_pkg;

   // Sizing of the bucket space, the slot pool and the tags held per slot.
   localparam int BUCKETS       = 1024;
   localparam int SLOTS         = 256;
   localparam int TAGS_PER_SLOT = 4;
   localparam int TAG_BITS      = 16;

   // Fixed field widths of the request and response channels.
   localparam int KIND_W     = 3;
   localparam int BUCKET_W   = 16;
   localparam int POS_W      = 2;
   localparam int VALUE_W    = 16;
   localparam int RSP_SLOT_W = 9;
   localparam int TOTAL_W    = 11;

   // Derived widths.
   localparam int MAP_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LEVEL_W     = $clog2(SLOTS + 1);
   localparam int ITEM_MAX    = SLOTS * TAGS_PER_SLOT;
   localparam int COUNT_W     = $clog2(ITEM_MAX + 1);
   localparam int TAG_IDX_W   = (TAGS_PER_SLOT > 1) ? $clog2(TAGS_PER_SLOT) : 1;
   localparam int NZ_W        = $clog2(TAGS_PER_SLOT + 1);
   localparam int CLEAR_COUNT = (BUCKETS > SLOTS) ? BUCKETS : SLOTS;
   localparam int CLR_W       = (CLEAR_COUNT > 1) ? $clog2(CLEAR_COUNT) : 1;

   // Request operation codes.
   typedef enum logic [KIND_W-1:0] {
      KIND_LOOKUP    = 3'd0,
      KIND_ACQUIRE   = 3'd1,
      KIND_RELEASE   = 3'd2,
      KIND_CLEAR     = 3'd3,
      KIND_WRITE_TAG = 3'd4
   } kind_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_TAG
   } state_type;

   // One entry of the bucket map.
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } map_entry_type;

   // All tags of one slot, stored as one memory row.
   typedef logic [TAGS_PER_SLOT-1:0][TAG_BITS-1:0] row_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic tag_read;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/sbsa_channels.sv */
`default_nettype none

// Request channel: one operation per transfer.
interface sbsa_req_if import sbsa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [BUCKET_W-1:0] bucket;
   logic [POS_W-1:0]    tag_position;
   logic [VALUE_W-1:0]  tag_value;

   modport source (output valid, kind, bucket, tag_position, tag_value, input ready);
   modport sink   (input valid, kind, bucket, tag_position, tag_value, output ready);
endinterface

// Response channel: one result per transfer.
interface sbsa_rsp_if import sbsa_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic signed [RSP_SLOT_W-1:0] slot;
   logic [TOTAL_W-1:0]           item_total;

   modport source (output valid, ok, slot, item_total, input ready);
   modport sink   (input valid, ok, slot, item_total, output ready);
endinterface

`default_nettype wire

/* rtl/sbsa_ctrl.sv */
`default_nettype none

module sbsa_ctrl import sbsa_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can be loaded when it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_MAP;
         end
         ST_MAP: begin
            state_in = ST_TAG;
         end
         ST_TAG: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_MAP: begin
            cmd.tag_read = 1'b1;
         end
         ST_TAG: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // A result stays valid until the sink takes it.
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // An accepted request walks through the map read and the tag read in order.
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == ST_MAP) ##1 (state_ff == ST_TAG))
      else $error("request did not follow the map and tag read sequence");

   // A commit always presents a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   // A finished operation waits while the previous result is stalled.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAG && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_TAG))
      else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

/* rtl/sbsa_datapath.sv */
`default_nettype none

module sbsa_datapath import sbsa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctrl_cmd_type         cmd,
   output dp_status_type             status,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [BUCKET_W-1:0]  req_bucket,
   input  wire logic [POS_W-1:0]     req_tag_position,
   input  wire logic [VALUE_W-1:0]   req_tag_value,
   output logic                      rsp_ok,
   output logic signed [RSP_SLOT_W-1:0] rsp_slot,
   output logic [TOTAL_W-1:0]        rsp_item_total
);

   // Latched request.
   logic [KIND_W-1:0]   kind_ff;
   logic [BUCKET_W-1:0] bucket_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [VALUE_W-1:0]  value_ff;

   // Memories and their registered read data.
   map_entry_type     map_mem [BUCKETS];
   logic [SLOT_W-1:0] stack_mem [SLOTS];
   row_type           tag_mem [SLOTS];
   map_entry_type     map_rd_ff;
   logic [SLOT_W-1:0] stack_rd_ff;
   row_type           tag_rd_ff;

   // Control registers.
   logic [CLR_W-1:0]   clr_cnt_ff;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Response payload.
   logic                         rsp_ok_ff, rsp_ok_in;
   logic signed [RSP_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // Decode of the read data.
   logic                     in_range, mapped, pos_valid, push_ok;
   logic [SLOT_W-1:0]        cur_slot, pop_slot;
   logic [TAGS_PER_SLOT-1:0] nz;
   logic [NZ_W-1:0]          nz_count;
   logic [TAG_BITS-1:0]      new_tag, old_tag;
   logic [TAG_IDX_W-1:0]     tag_idx;

   // Operation results.
   logic              ok, out_mapped;
   logic [SLOT_W-1:0] out_slot;
   logic              map_we, stack_we, tag_we;
   map_entry_type     map_wdata;
   row_type           tag_wdata;

   // Memory port muxes.
   logic              map_port_we, stack_port_we;
   logic [MAP_W-1:0]  map_port_addr;
   map_entry_type     map_port_data;
   logic [SLOT_W-1:0] stack_port_addr, stack_port_data;

   assign status.clear_last = (32'(clr_cnt_ff) == CLEAR_COUNT - 1);

   // Capture the request on its transfer.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= req_kind;
         bucket_ff <= req_bucket;
         pos_ff    <= req_tag_position;
         value_ff  <= req_tag_value;
      end
   end

   // Clearing sweep over the map and the free stack after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step && !status.clear_last) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Decode of the map entry and tag row.
   always_comb begin
      in_range  = 32'(bucket_ff) < BUCKETS;
      cur_slot  = map_rd_ff.slot;
      mapped    = in_range && map_rd_ff.valid && (32'(map_rd_ff.slot) < SLOTS);
      pos_valid = 32'(pos_ff) < TAGS_PER_SLOT;
      push_ok   = 32'(level_ff) < SLOTS;
      pop_slot  = (32'(stack_rd_ff) < SLOTS) ? stack_rd_ff : '0;
      tag_idx   = TAG_IDX_W'(pos_ff);
      new_tag   = TAG_BITS'(value_ff);
      old_tag   = tag_rd_ff[tag_idx];
      for (int i = 0; i < TAGS_PER_SLOT; i++) begin
         nz[i] = tag_rd_ff[i] != '0;
      end
      nz_count  = NZ_W'($countones(nz));
   end

   // Operation decode: result, memory writes and register updates.
   always_comb begin
      ok              = 1'b0;
      out_mapped      = mapped;
      out_slot        = cur_slot;
      map_we          = 1'b0;
      map_wdata       = '0;
      stack_we        = 1'b0;
      tag_we          = 1'b0;
      tag_wdata       = '0;
      level_in        = level_ff;
      count_in        = count_ff;
      case (kind_type'(kind_ff))
         KIND_LOOKUP: begin
            ok = mapped;
         end
         KIND_ACQUIRE: begin
            if (mapped) begin
               ok = 1'b1;
            end else if (in_range && level_ff != '0) begin
               // Pop a free slot and start it with all tags empty.
               ok             = 1'b1;
               out_mapped     = 1'b1;
               out_slot       = pop_slot;
               map_we         = 1'b1;
               map_wdata.valid = 1'b1;
               map_wdata.slot = pop_slot;
               tag_we         = 1'b1;
               level_in       = level_ff - 1'b1;
            end
         end
         KIND_RELEASE: begin
            if (!mapped) begin
               ok = 1'b1;
            end else if (nz == '0) begin
               ok         = 1'b1;
               out_mapped = 1'b0;
               map_we     = 1'b1;
               if (push_ok) begin
                  stack_we = 1'b1;
                  level_in = level_ff + 1'b1;
               end
            end
         end
         KIND_CLEAR: begin
            if (mapped) begin
               // Drop every held tag from the count, floored at zero.
               ok         = 1'b1;
               out_mapped = 1'b0;
               map_we     = 1'b1;
               tag_we     = 1'b1;
               count_in   = (count_ff >= COUNT_W'(nz_count)) ?
                            count_ff - COUNT_W'(nz_count) : '0;
               if (push_ok) begin
                  stack_we = 1'b1;
                  level_in = level_ff + 1'b1;
               end
            end
         end
         KIND_WRITE_TAG: begin
            if (mapped && pos_valid) begin
               ok                 = 1'b1;
               tag_we             = 1'b1;
               tag_wdata          = tag_rd_ff;
               tag_wdata[tag_idx] = new_tag;
               if (old_tag == '0 && new_tag != '0) begin
                  if (32'(count_ff) < ITEM_MAX) count_in = count_ff + 1'b1;
               end else if (old_tag != '0 && new_tag == '0) begin
                  if (count_ff != '0) count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      rsp_ok_in   = ok;
      rsp_slot_in = out_mapped ? RSP_SLOT_W'(out_slot) : '1;
   end

   // Write port selection: the clearing sweep or a committed operation.
   always_comb begin
      if (cmd.clear_step) begin
         map_port_we     = 32'(clr_cnt_ff) < BUCKETS;
         map_port_addr   = clr_cnt_ff[MAP_W-1:0];
         map_port_data   = '0;
         stack_port_we   = 32'(clr_cnt_ff) < SLOTS;
         stack_port_addr = clr_cnt_ff[SLOT_W-1:0];
         stack_port_data = SLOT_W'(32'(SLOTS - 1) - 32'(clr_cnt_ff));
      end else begin
         map_port_we     = cmd.commit && map_we;
         map_port_addr   = bucket_ff[MAP_W-1:0];
         map_port_data   = map_wdata;
         stack_port_we   = cmd.commit && stack_we;
         stack_port_addr = level_ff[SLOT_W-1:0];
         stack_port_data = cur_slot;
      end
   end

   // Bucket map memory.
   always_ff @(posedge clock) begin
      if (map_port_we) map_mem[map_port_addr] <= map_port_data;
      if (cmd.accept)  map_rd_ff <= map_mem[req_bucket[MAP_W-1:0]];
   end

   // Free stack memory; the top entry is read when a request arrives.
   always_ff @(posedge clock) begin
      if (stack_port_we) stack_mem[stack_port_addr] <= stack_port_data;
      if (cmd.accept)    stack_rd_ff <= stack_mem[SLOT_W'(level_ff - 1'b1)];
   end

   // Tag row memory, one row per slot.
   always_ff @(posedge clock) begin
      if (cmd.commit && tag_we) begin
         tag_mem[out_mapped ? out_slot : cur_slot] <= tag_wdata;
      end
      if (cmd.tag_read) tag_rd_ff <= tag_mem[map_rd_ff.slot];
   end

   // Stack level and tag count.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_W'(SLOTS);
         count_ff <= '0;
      end else if (cmd.commit) begin
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_slot_ff <= rsp_slot_in;
      end
   end

   assign rsp_ok         = rsp_ok_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_item_total = TOTAL_W'(count_ff);

`ifndef SYNTHESIS
   // The free stack never holds more slots than the pool has.
   assert property (@(posedge clock) disable iff (reset)
      32'(level_ff) <= SLOTS)
      else $error("free stack level above pool size");

   // The tag count stays within the pool's capacity.
   assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= ITEM_MAX)
      else $error("tag count above capacity");
`endif

endmodule

`default_nettype wire

/* rtl/sparse_bucket_slot_allocator_core.sv */
`default_nettype none

// Maps global bucket numbers onto a pool of local slots of four tags each, with a
// free stack supplying slots to acquire requests. Each request goes through three
// steps in order. The first is the transfer cycle, and its closing edge reads the
// bucket map and the top of the free stack. The second reads the slot's tag row. The
// third updates the map, stack and tags, writes them back and loads the result. The
// next request is not accepted until the third step is done. A new request can be
// taken while the previous result still waits for the sink. A stalled result holds
// the third step of the following request. After reset the block clears the bucket
// map and refills the free stack in a clearing pass, during which no request is
// taken. Responses report the slot after the operation (all ones when none) and the
// running count of nonzero tags.
module sparse_bucket_slot_allocator_core import sbsa_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   sbsa_req_if.sink   req,
   sbsa_rsp_if.source rsp
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencing of the clear pass and each request.
   sbsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Map, stack and tag storage with the operation logic.
   sbsa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req.kind),
      .req_bucket       (req.bucket),
      .req_tag_position (req.tag_position),
      .req_tag_value    (req.tag_value),
      .rsp_ok           (rsp.ok),
      .rsp_slot         (rsp.slot),
      .rsp_item_total   (rsp.item_total)
   );

endmodule

`default_nettype wire
